// ===== rtl/core/owm_pkg.sv =====
`default_nettype none

package owm_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] CFG_PRESENCE_TAIL = 3'd2;
  localparam logic [2:0] CFG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] CFG_READ_SAMPLE   = 3'd4;
  localparam logic [2:0] CFG_READ_TAIL     = 3'd5;
  localparam logic [2:0] CFG_LONG_SLOT     = 3'd6;
  localparam logic [2:0] CFG_RECOVERY      = 3'd7;

  localparam int unsigned TimeW = 10;

  // Timing register reset values, in ticks
  localparam logic [TimeW-1:0] RST_RESET_LOW     = 10'd480;
  localparam logic [TimeW-1:0] RST_PRESENCE_WAIT = 10'd40;
  localparam logic [TimeW-1:0] RST_PRESENCE_TAIL = 10'd120;
  localparam logic [TimeW-1:0] RST_SHORT_LOW     = 10'd1;
  localparam logic [TimeW-1:0] RST_READ_SAMPLE   = 10'd14;
  localparam logic [TimeW-1:0] RST_READ_TAIL     = 10'd45;
  localparam logic [TimeW-1:0] RST_LONG_SLOT     = 10'd60;
  localparam logic [TimeW-1:0] RST_RECOVERY      = 10'd5;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_RST_LOW   = 7'b0000010,
    PH_PRES_WAIT = 7'b0000100,
    PH_PRES_TAIL = 7'b0001000,
    PH_SLOT_LOW  = 7'b0010000,
    PH_SLOT_REL  = 7'b0100000,
    PH_SLOT_TAIL = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_data;
    logic       line_level;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       no_presence;
    logic [7:0] read_data;
    logic [7:0] crc_value;
    logic       status;
  } owm_out_t;

  typedef struct packed {
    logic [TimeW-1:0] reset_low_time;
    logic [TimeW-1:0] presence_wait_time;
    logic [TimeW-1:0] presence_tail_time;
    logic [TimeW-1:0] short_low_time;
    logic [TimeW-1:0] read_sample_time;
    logic [TimeW-1:0] read_tail_time;
    logic [TimeW-1:0] long_slot_time;
    logic [TimeW-1:0] recovery_time;
  } owm_cfg_t;

  // Reflected CRC-8 over one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    logic       fb;
    c = crc_in;
    b = data;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[0];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/owm_cfg_regs.sv =====
`default_nettype none

module owm_cfg_regs
  import owm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [2:0]       wr_index_i,
  input  wire logic [TimeW-1:0] wr_data_i,
  output owm_cfg_t              cfg_o
);

  owm_cfg_t cfg_q;
  owm_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_RESET_LOW:     cfg_d.reset_low_time     = wr_data_i;
        CFG_PRESENCE_WAIT: cfg_d.presence_wait_time = wr_data_i;
        CFG_PRESENCE_TAIL: cfg_d.presence_tail_time = wr_data_i;
        CFG_SHORT_LOW:     cfg_d.short_low_time     = wr_data_i;
        CFG_READ_SAMPLE:   cfg_d.read_sample_time   = wr_data_i;
        CFG_READ_TAIL:     cfg_d.read_tail_time     = wr_data_i;
        CFG_LONG_SLOT:     cfg_d.long_slot_time     = wr_data_i;
        CFG_RECOVERY:      cfg_d.recovery_time      = wr_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time     <= RST_RESET_LOW;
      cfg_q.presence_wait_time <= RST_PRESENCE_WAIT;
      cfg_q.presence_tail_time <= RST_PRESENCE_TAIL;
      cfg_q.short_low_time     <= RST_SHORT_LOW;
      cfg_q.read_sample_time   <= RST_READ_SAMPLE;
      cfg_q.read_tail_time     <= RST_READ_TAIL;
      cfg_q.long_slot_time     <= RST_LONG_SLOT;
      cfg_q.recovery_time      <= RST_RECOVERY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/owm_step.sv =====
`default_nettype none

module owm_step
  import owm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire owm_in_t  item_i,
  input  wire owm_cfg_t cfg_i,
  output owm_out_t     result_o
);

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] tick_count_q, tick_count_d;
  logic [2:0]       bit_index_q, bit_index_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       crc_q, crc_d;
  logic             presence_q, presence_d;
  logic             drive_q, drive_d;
  logic             reading_q, reading_d;
  logic [7:0]       last_read_q, last_read_d;

  always_comb begin
    logic [TimeW-1:0] len_raw;
    logic [TimeW-1:0] len;
    logic [TimeW:0]   count;
    logic [TimeW-1:0] tail_sel;
    logic [7:0]       shift_v;
    logic             end_slot;
    logic             done;
    logic             status;

    phase_d      = phase_q;
    tick_count_d = tick_count_q;
    bit_index_d  = bit_index_q;
    shift_d      = shift_q;
    crc_d        = crc_q;
    presence_d   = presence_q;
    drive_d      = drive_q;
    reading_d    = reading_q;
    last_read_d  = last_read_q;
    done         = 1'b0;
    status       = 1'b0;
    end_slot     = 1'b0;
    shift_v      = shift_q;
    count        = {1'b0, tick_count_q} + {{TimeW{1'b0}}, 1'b1};
    tail_sel     = reading_q ? cfg_i.read_tail_time : cfg_i.recovery_time;

    case (phase_q)
      PH_RST_LOW:   len_raw = cfg_i.reset_low_time;
      PH_PRES_WAIT: len_raw = cfg_i.presence_wait_time;
      PH_PRES_TAIL: len_raw = cfg_i.presence_tail_time;
      PH_SLOT_LOW:  len_raw = (reading_q || shift_q[0]) ? cfg_i.short_low_time
                                                        : cfg_i.long_slot_time;
      PH_SLOT_REL: begin
        if (reading_q) begin
          len_raw = cfg_i.read_sample_time;
        end else begin
          len_raw = shift_q[0] ? cfg_i.long_slot_time : cfg_i.short_low_time;
        end
      end
      PH_SLOT_TAIL: len_raw = tail_sel;
      default:      len_raw = {{(TimeW-1){1'b0}}, 1'b1};
    endcase
    len = (len_raw == '0) ? {{(TimeW-1){1'b0}}, 1'b1} : len_raw;

    if (fire_i) begin
      if (item_i.kind == KIND_TICK) begin
        if (phase_q != PH_IDLE) begin
          if (count < {1'b0, len}) begin
            tick_count_d = count[TimeW-1:0];
          end else begin
            tick_count_d = '0;
            case (phase_q)
              PH_RST_LOW: begin
                phase_d = PH_PRES_WAIT;
                drive_d = 1'b0;
              end
              PH_PRES_WAIT: begin
                presence_d = item_i.line_level;
                drive_d    = 1'b0;
                if (cfg_i.presence_tail_time != '0) begin
                  phase_d = PH_PRES_TAIL;
                end else begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
              end
              PH_PRES_TAIL: begin
                phase_d = PH_IDLE;
                drive_d = 1'b0;
                done    = 1'b1;
              end
              PH_SLOT_LOW: begin
                phase_d = PH_SLOT_REL;
                drive_d = 1'b0;
              end
              PH_SLOT_REL: begin
                if (reading_q) begin
                  shift_v = {item_i.line_level, shift_q[7:1]};
                end
                shift_d = shift_v;
                if (tail_sel != '0) begin
                  phase_d = PH_SLOT_TAIL;
                  drive_d = 1'b0;
                end else begin
                  end_slot = 1'b1;
                end
              end
              PH_SLOT_TAIL: end_slot = 1'b1;
              default: begin
                phase_d = PH_IDLE;
                drive_d = 1'b0;
              end
            endcase

            // Close the bit slot: finish the byte or open the next slot
            if (end_slot) begin
              if (bit_index_q == 3'd7) begin
                if (reading_q) begin
                  last_read_d = shift_v;
                  crc_d       = crc8_byte(crc_q, shift_v);
                end
                bit_index_d = '0;
                phase_d     = PH_IDLE;
                drive_d     = 1'b0;
                done        = 1'b1;
              end else begin
                bit_index_d = bit_index_q + 3'd1;
                if (!reading_q) begin
                  shift_d = {1'b0, shift_v[7:1]};
                end
                phase_d = PH_SLOT_LOW;
                drive_d = 1'b1;
              end
            end
          end
        end
      end else if (phase_q != PH_IDLE) begin
        status = 1'b1;
      end else begin
        bit_index_d  = '0;
        tick_count_d = '0;
        drive_d      = 1'b1;
        if (item_i.kind == KIND_RESET) begin
          crc_d   = '0;
          phase_d = PH_RST_LOW;
        end else begin
          reading_d = (item_i.kind == KIND_READ);
          shift_d   = (item_i.kind == KIND_READ) ? 8'h00 : item_i.write_data;
          phase_d   = PH_SLOT_LOW;
        end
      end
    end

    result_o.drive_low   = drive_d;
    result_o.busy_res    = (phase_d != PH_IDLE);
    result_o.done_res    = done;
    result_o.no_presence = presence_d;
    result_o.read_data   = last_read_d;
    result_o.crc_value   = crc_d;
    result_o.status      = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      tick_count_q <= '0;
      bit_index_q  <= '0;
      shift_q      <= '0;
      crc_q        <= '0;
      presence_q   <= 1'b0;
      drive_q      <= 1'b0;
      reading_q    <= 1'b0;
      last_read_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      tick_count_q <= tick_count_d;
      bit_index_q  <= bit_index_d;
      shift_q      <= shift_d;
      crc_q        <= crc_d;
      presence_q   <= presence_d;
      drive_q      <= drive_d;
      reading_q    <= reading_d;
      last_read_q  <= last_read_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/one_wire_master_slot_engine.sv =====
// 1-Wire bus master slot engine.
// Input channel (in_valid_i / in_stall_o / in_item_i): each item is a tick carrying the
// sampled bus level, or a reset, write-byte or read-byte command. Output channel
// (out_valid_o / out_stall_i / out_item_o): exactly one result item per input item, in
// order, giving line drive, busy, done, presence, last read byte, CRC and status.
// Config channel (cfg_valid_i / cfg_ready_o): eight 10-bit timing registers in ticks;
// always ready, write only while the engine is idle.
// An item lands in the input register at its accept edge; its result is then
// registered in the result register once that register is free or being taken.
// Throughput: one item per clock unless the receiver stalls. The slot state machine,
// tick counter and byte CRC update all settle between the input and result registers.
// When the receiver stalls, the result register holds and the input register takes
// one more item, then in_stall_o rises; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous): timing registers return to their defaults, the
// engine goes idle with the line released, CRC, presence and read byte cleared, and
// both pipeline registers empty.

`default_nettype none

module one_wire_master_slot_engine
  import owm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire owm_in_t          in_item_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output owm_out_t              out_item_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [TimeW-1:0] cfg_data_i
);

  owm_cfg_t cfg;
  owm_out_t result;

  logic     in_valid_q;
  owm_in_t  in_item_q;
  logic     out_valid_q;
  owm_out_t out_item_q;
  logic     advance;
  logic     fire;

  assign cfg_ready_o = 1'b1;

  owm_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the pipeline whenever the result register is free or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  owm_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register: load a new item unless the held one is blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== sim/owm_slot_checker.sv =====
module owm_slot_checker
  import owm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  owm_in_t    in_item_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  owm_out_t   out_item_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  output logic       engine_busy_o,
  output int         results_due_o,
  output int         fail_count_o,
  output int         checked_o,
  output int         rejected_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the engine: timing registers and slot state
  owm_cfg_t   timing;
  phase_e     eng_phase;
  int         eng_count;
  logic [2:0] eng_bit;
  logic [7:0] eng_shift;
  logic [7:0] eng_crc;
  logic       eng_presence;
  logic       eng_drive;
  logic       eng_reading;
  logic [7:0] eng_last_read;

  owm_out_t slot_results_q[$];
  int mismatches = 0;
  int results_checked = 0;
  int rejected_cmds = 0;

  assign fail_count_o = mismatches;
  assign checked_o    = results_checked;
  assign rejected_o   = rejected_cmds;

  function automatic int floor_one(input logic [9:0] v);
    return (v == 10'd0) ? 1 : int'(v);
  endfunction

  // Reflected CRC-8, one data bit per step
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    int         i;
    c = crc;
    for (i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void enter_phase(input phase_e p);
    eng_phase = p;
    eng_count = 0;
    eng_drive = (p == PH_RST_LOW) || (p == PH_SLOT_LOW);
  endfunction

  function automatic int phase_ticks();
    case (eng_phase)
      PH_RST_LOW:   return floor_one(timing.reset_low_time);
      PH_PRES_WAIT: return floor_one(timing.presence_wait_time);
      PH_PRES_TAIL: return floor_one(timing.presence_tail_time);
      PH_SLOT_LOW: begin
        if (eng_reading || eng_shift[0]) return floor_one(timing.short_low_time);
        return floor_one(timing.long_slot_time);
      end
      PH_SLOT_REL: begin
        if (eng_reading) return floor_one(timing.read_sample_time);
        if (eng_shift[0]) return floor_one(timing.long_slot_time);
        return floor_one(timing.short_low_time);
      end
      PH_SLOT_TAIL: begin
        if (eng_reading) return floor_one(timing.read_tail_time);
        return floor_one(timing.recovery_time);
      end
      default: return 1;
    endcase
  endfunction

  // Close one bit slot; report whether the byte is complete
  function automatic logic close_slot();
    if (eng_bit == 3'd7) begin
      if (eng_reading) begin
        eng_last_read = eng_shift;
        eng_crc       = crc_fold(eng_crc, eng_shift);
      end
      eng_bit = 3'd0;
      enter_phase(PH_IDLE);
      return 1'b1;
    end
    eng_bit = eng_bit + 3'd1;
    if (!eng_reading) eng_shift = eng_shift >> 1;
    enter_phase(PH_SLOT_LOW);
    return 1'b0;
  endfunction

  // Advance one tick; report completion of a sequence
  function automatic logic advance_tick(input logic level);
    int cnt;
    if (eng_phase == PH_IDLE) return 1'b0;
    cnt = eng_count + 1;
    if (cnt < phase_ticks()) begin
      eng_count = cnt;
      return 1'b0;
    end
    case (eng_phase)
      PH_RST_LOW: begin
        enter_phase(PH_PRES_WAIT);
        return 1'b0;
      end
      PH_PRES_WAIT: begin
        eng_presence = level;
        if (timing.presence_tail_time != 10'd0) begin
          enter_phase(PH_PRES_TAIL);
          return 1'b0;
        end
        enter_phase(PH_IDLE);
        return 1'b1;
      end
      PH_PRES_TAIL: begin
        enter_phase(PH_IDLE);
        return 1'b1;
      end
      PH_SLOT_LOW: begin
        enter_phase(PH_SLOT_REL);
        return 1'b0;
      end
      PH_SLOT_REL: begin
        if (eng_reading) eng_shift = {level, eng_shift[7:1]};
        if ((eng_reading ? timing.read_tail_time : timing.recovery_time) != 10'd0) begin
          enter_phase(PH_SLOT_TAIL);
          return 1'b0;
        end
        return close_slot();
      end
      PH_SLOT_TAIL: return close_slot();
      default: begin
        enter_phase(PH_IDLE);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic owm_out_t next_bus_result(input owm_in_t it);
    owm_out_t r;
    logic     done;
    logic     rejected;
    done     = 1'b0;
    rejected = 1'b0;
    if (it.kind == KIND_TICK) begin
      done = advance_tick(it.line_level);
    end else if (eng_phase != PH_IDLE) begin
      rejected = 1'b1;
      rejected_cmds++;
    end else begin
      eng_bit = 3'd0;
      if (it.kind == KIND_RESET) begin
        eng_crc = 8'h00;
        enter_phase(PH_RST_LOW);
      end else begin
        eng_reading = (it.kind == KIND_READ);
        eng_shift   = eng_reading ? 8'h00 : it.write_data;
        enter_phase(PH_SLOT_LOW);
      end
    end
    r.drive_low   = eng_drive;
    r.busy_res    = (eng_phase != PH_IDLE);
    r.done_res    = done;
    r.no_presence = eng_presence;
    r.read_data   = eng_last_read;
    r.crc_value   = eng_crc;
    r.status      = rejected;
    return r;
  endfunction

  function automatic void reset_engine();
    timing.reset_low_time     = RST_RESET_LOW;
    timing.presence_wait_time = RST_PRESENCE_WAIT;
    timing.presence_tail_time = RST_PRESENCE_TAIL;
    timing.short_low_time     = RST_SHORT_LOW;
    timing.read_sample_time   = RST_READ_SAMPLE;
    timing.read_tail_time     = RST_READ_TAIL;
    timing.long_slot_time     = RST_LONG_SLOT;
    timing.recovery_time      = RST_RECOVERY;
    eng_phase     = PH_IDLE;
    eng_count     = 0;
    eng_bit       = 3'd0;
    eng_shift     = 8'h00;
    eng_crc       = 8'h00;
    eng_presence  = 1'b0;
    eng_drive     = 1'b0;
    eng_reading   = 1'b0;
    eng_last_read = 8'h00;
  endfunction

  function automatic void load_register(input logic [2:0] idx, input logic [9:0] val);
    case (idx)
      CFG_RESET_LOW:     timing.reset_low_time     = val;
      CFG_PRESENCE_WAIT: timing.presence_wait_time = val;
      CFG_PRESENCE_TAIL: timing.presence_tail_time = val;
      CFG_SHORT_LOW:     timing.short_low_time     = val;
      CFG_READ_SAMPLE:   timing.read_sample_time   = val;
      CFG_READ_TAIL:     timing.read_tail_time     = val;
      CFG_LONG_SLOT:     timing.long_slot_time     = val;
      default:           timing.recovery_time      = val;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(input owm_out_t want, input owm_out_t seen);
    check_field("drive_low",   8'(want.drive_low),   8'(seen.drive_low));
    check_field("busy_res",    8'(want.busy_res),    8'(seen.busy_res));
    check_field("done_res",    8'(want.done_res),    8'(seen.done_res));
    check_field("no_presence", 8'(want.no_presence), 8'(seen.no_presence));
    check_field("read_data",   want.read_data,       seen.read_data);
    check_field("crc_value",   want.crc_value,       seen.crc_value);
    check_field("status",      8'(want.status),      8'(seen.status));
    results_checked++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_engine();
      slot_results_q.delete();
      engine_busy_o <= 1'b0;
      results_due_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) load_register(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (slot_results_q.size() == 0) begin
          $error("result item arrived with no input item pending");
          mismatches++;
        end else begin
          compare_result(slot_results_q.pop_front(), out_item_i);
        end
      end
      if (in_valid_i && !in_stall_i) slot_results_q.push_back(next_bus_result(in_item_i));
      engine_busy_o <= (eng_phase != PH_IDLE);
      results_due_o <= slot_results_q.size();
    end
  end

endmodule

// ===== sim/tb_one_wire_master_slot_engine.sv =====
module tb_one_wire_master_slot_engine;
  import owm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 180;
  localparam int LEVEL_LOW    = 0;
  localparam int LEVEL_HIGH   = 1;
  localparam int LEVEL_RANDOM = 2;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  owm_in_t    in_item_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  owm_out_t   out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = CFG_RESET_LOW;
  logic [9:0] cfg_data_i  = '0;

  logic eng_busy;
  int   results_due;
  int   fail_count;
  int   results_checked;
  int   rejected_cmds;

  int   items_sent    = 0;
  int   settings_used = 1;
  int   idle_run      = 0;
  logic no_gaps       = 1'b0;

  one_wire_master_slot_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  owm_slot_checker slot_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_i    (out_item_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .engine_busy_o (eng_busy),
    .results_due_o (results_due),
    .fail_count_o  (fail_count),
    .checked_o     (results_checked),
    .rejected_o    (rejected_cmds)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: end the run when no channel has moved anything for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run == STALL_LIMIT) begin
      $display("tb_one_wire_master_slot_engine failed");
      $finish;
    end
  end

  // Result side: hold stall for a random number of cycles, then take one item.
  // In no-gap stretches take results back to back.
  initial begin : result_sink
    int gap;
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one input item after a random gap and hold it until accepted.
  // On return the item went in at the edge just passed and valid is still high.
  task automatic push_item(input owm_in_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Keep cfg_valid high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_timing(input owm_cfg_t t);
    write_reg(CFG_RESET_LOW,     t.reset_low_time);
    write_reg(CFG_PRESENCE_WAIT, t.presence_wait_time);
    write_reg(CFG_PRESENCE_TAIL, t.presence_tail_time);
    write_reg(CFG_SHORT_LOW,     t.short_low_time);
    write_reg(CFG_READ_SAMPLE,   t.read_sample_time);
    write_reg(CFG_READ_TAIL,     t.read_tail_time);
    write_reg(CFG_LONG_SLOT,     t.long_slot_time);
    write_reg(CFG_RECOVERY,      t.recovery_time);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  function automatic owm_cfg_t uniform_timing(input logic [9:0] v);
    owm_cfg_t t;
    t = {8{v}};
    return t;
  endfunction

  // Mostly tiny durations so sequences stay short; now and then a longer one
  function automatic logic [9:0] short_time();
    if ($urandom_range(0, 9) == 0) return 10'($urandom_range(6, 40));
    return 10'($urandom_range(0, 5));
  endfunction

  function automatic owm_cfg_t random_timing();
    owm_cfg_t t;
    t.reset_low_time     = short_time();
    t.presence_wait_time = short_time();
    t.presence_tail_time = short_time();
    t.short_low_time     = short_time();
    t.read_sample_time   = short_time();
    t.read_tail_time     = short_time();
    t.long_slot_time     = short_time();
    t.recovery_time      = short_time();
    return t;
  endfunction

  // Issue a command, then feed ticks until the engine goes idle again.
  // eng_busy as read right after an edge reflects the item before the one just
  // taken, so the loop always feeds at least one item past the command.
  // poke_pct injects commands mid-sequence, which the engine must reject while busy.
  task automatic run_command(input logic [1:0] kind, input logic [7:0] data,
                             input int level_mode, input int poke_pct);
    owm_in_t it;
    no_gaps       = ($urandom_range(0, 3) == 0);
    it.kind       = kind;
    it.write_data = data;
    it.line_level = 1'($urandom_range(0, 1));
    push_item(it);
    do begin
      if ($urandom_range(0, 99) < poke_pct) begin
        it.kind = 2'($urandom_range(KIND_RESET, KIND_READ));
      end else begin
        it.kind = KIND_TICK;
      end
      it.write_data = 8'($urandom);
      if (level_mode == LEVEL_RANDOM) begin
        it.line_level = 1'($urandom_range(0, 1));
      end else begin
        it.line_level = (level_mode == LEVEL_HIGH);
      end
      push_item(it);
    end while (eng_busy);
  endtask

  // Short run of arbitrary items: idle ticks, stray commands, half-started sequences
  task automatic noise_burst();
    owm_in_t it;
    int      n;
    no_gaps = ($urandom_range(0, 3) == 0);
    n = $urandom_range(1, 5);
    repeat (n) begin
      it.kind       = 2'($urandom_range(0, 3));
      it.write_data = 8'($urandom);
      it.line_level = 1'($urandom_range(0, 1));
      push_item(it);
    end
  endtask

  // Bring the engine back to idle and wait for every result before touching config
  task automatic settle();
    owm_in_t it;
    it.kind = KIND_TICK;
    do begin
      it.write_data = 8'($urandom);
      it.line_level = 1'($urandom_range(0, 1));
      push_item(it);
    end while (eng_busy);
    in_valid_i <= 1'b0;
    // let the checker see the last item so it is counted as pending before we wait on it
    @(posedge clk_i);
    wait (results_due == 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int start;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: a full bus reset at power-up timing, with a few stray commands
    run_command(KIND_RESET, 8'h00, LEVEL_LOW, 1);
    settle();

    // All zero: low and wait times act as one tick, tails and recovery are skipped.
    // Heavy poking here so each command kind is rejected while busy.
    load_timing(uniform_timing(10'd0));
    run_command(KIND_RESET, 8'h00, LEVEL_HIGH, 30);
    run_command(KIND_RESET, 8'h00, LEVEL_LOW, 30);
    run_command(KIND_WRITE, 8'h00, LEVEL_RANDOM, 30);
    run_command(KIND_WRITE, 8'hFF, LEVEL_RANDOM, 30);
    run_command(KIND_READ, 8'h00, LEVEL_HIGH, 30);
    run_command(KIND_READ, 8'h00, LEVEL_LOW, 30);
    run_command(KIND_READ, 8'h00, LEVEL_RANDOM, 30);
    settle();

    // All one tick: every tail phase present but minimal
    load_timing(uniform_timing(10'd1));
    run_command(KIND_WRITE, 8'h5A, LEVEL_RANDOM, 10);
    run_command(KIND_READ, 8'h00, LEVEL_RANDOM, 10);
    run_command(KIND_RESET, 8'h00, LEVEL_RANDOM, 10);
    settle();

    // Random part: fresh small timing per setting, mostly complete command
    // sequences with random bus levels, the rest noise
    repeat (4) begin
      load_timing(random_timing());
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          run_command(2'($urandom_range(KIND_RESET, KIND_READ)), 8'($urandom),
                      LEVEL_RANDOM, 4);
        end else begin
          noise_burst();
        end
      end
      settle();
    end

    $display("covered %0d input items over %0d timing settings", items_sent, settings_used);
    $display("compared %0d result items, %0d commands turned away while busy",
             results_checked, rejected_cmds);
    if (fail_count == 0) begin
      $display("tb_one_wire_master_slot_engine passed");
    end else begin
      $display("tb_one_wire_master_slot_engine failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/owm_pkg.sv
rtl/core/owm_cfg_regs.sv
rtl/core/owm_step.sv
rtl/core/one_wire_master_slot_engine.sv
sim/owm_slot_checker.sv
sim/tb_one_wire_master_slot_engine.sv
